>>> src/tone_sequencer_with_sweep_defines.svh
// Assertion helpers shared by the RTL. Clock and reset are the block's own.
`ifndef TONE_SEQUENCER_WITH_SWEEP_DEFINES_SVH
`define TONE_SEQUENCER_WITH_SWEEP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tss: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define TSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tss: next-cycle check failed");

`endif

>>> src/tss_pkg.sv
package tss_pkg;

    // Default table size and configuration reset values
    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int NUMERATOR_W       = 24;
    localparam int TPS_W             = 10;
    localparam int FREQ_W            = 16;
    localparam int CFG_IDX_W         = 1;
    localparam logic [NUMERATOR_W-1:0] NUMERATOR_RST = 24'd4200000;
    localparam logic [TPS_W-1:0]       TPS_RST       = 10'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS       = 1'b1;

    // Request action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    // Bit-serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = NUMERATOR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Microcode step counter width
    localparam int UPC_W = 5;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         entry_index;
        logic [15:0]        entry_length;
        logic [15:0]        entry_note;
        logic signed [15:0] entry_sweep;
        logic [7:0]         start_index;
    } tss_in_t;

    typedef struct packed {
        logic        tone_on;
        logic [23:0] divider;
        logic        divider_written;
    } tss_out_t;

    // One note table entry
    typedef struct packed {
        logic [15:0] length;
        logic [15:0] note;
        logic [15:0] sweep;
    } tss_entry_t;

    // Datapath operations selected by the control word
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_START,
        OP_TICK,
        OP_SWEEP,
        OP_DIV_START,
        OP_DIV_STORE,
        OP_FETCH,
        OP_DEC,
        OP_STOP,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_REQ,
        C_NOT_LOAD,
        C_NOT_START,
        C_NOT_RUN_TICK,
        C_NO_STEP,
        C_SKIP_SWEEP_DIV,
        C_DIV_BUSY,
        C_STEPS_LEFT,
        C_LEN_ZERO,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } tss_ctrl_t;

    // Status from the datapath, tested by the sequencer
    typedef struct packed {
        logic req;
        logic is_load;
        logic is_start;
        logic run_tick;
        logic step_due;
        logic skip_sweep_div;
        logic div_busy;
        logic steps_nonzero;
        logic len_zero;
        logic out_busy;
    } tss_flags_t;

endpackage

>>> src/tss_divider.sv
module tss_divider
    import tss_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [NUMERATOR_W-1:0] numerator,
    input  logic [FREQ_W-1:0]      denominator,
    output logic                   busy,
    output logic [NUMERATOR_W-1:0] quotient
);

    logic                   busy_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [NUMERATOR_W-1:0] q_reg;
    logic [FREQ_W-1:0]      rem_reg;
    logic [FREQ_W-1:0]      den_reg;

    logic [FREQ_W:0]        trial;
    logic                   ge;
    logic [FREQ_W-1:0]      rem_next;
    logic [NUMERATOR_W-1:0] q_next;

    // Restoring step; a zero divisor always subtracts, giving all ones
    always_comb begin
        trial    = {rem_reg, q_reg[NUMERATOR_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? FREQ_W'(trial - {1'b0, den_reg}) : trial[FREQ_W-1:0];
        q_next   = {q_reg[NUMERATOR_W-2:0], ge};
    end

    // Iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= numerator;
            rem_reg <= '0;
            den_reg <= denominator;
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

>>> src/tss_note_ram.sv
module tss_note_ram
    import tss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  tss_entry_t    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output tss_entry_t    rd_data
);

    tss_entry_t mem [TABLE_DEPTH];
    tss_entry_t rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/tss_ucode.sv
module tss_ucode
    import tss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  tss_flags_t flags,
    output tss_ctrl_t  ctrl
);

    // Program addresses
    localparam logic [UPC_W-1:0] S_IDLE      = 5'd0;
    localparam logic [UPC_W-1:0] S_CHK_LOAD  = 5'd1;
    localparam logic [UPC_W-1:0] S_LOAD      = 5'd2;
    localparam logic [UPC_W-1:0] S_CHK_START = 5'd3;
    localparam logic [UPC_W-1:0] S_START     = 5'd4;
    localparam logic [UPC_W-1:0] S_CHK_TICK  = 5'd5;
    localparam logic [UPC_W-1:0] S_TICK      = 5'd6;
    localparam logic [UPC_W-1:0] S_SWEEP     = 5'd7;
    localparam logic [UPC_W-1:0] S_SDIV_GO   = 5'd8;
    localparam logic [UPC_W-1:0] S_SDIV_WAIT = 5'd9;
    localparam logic [UPC_W-1:0] S_CHK_STEPS = 5'd10;
    localparam logic [UPC_W-1:0] S_FETCH     = 5'd11;
    localparam logic [UPC_W-1:0] S_FDIV_GO   = 5'd12;
    localparam logic [UPC_W-1:0] S_FDIV_WAIT = 5'd13;
    localparam logic [UPC_W-1:0] S_DEC       = 5'd14;
    localparam logic [UPC_W-1:0] S_STOP      = 5'd15;
    localparam logic [UPC_W-1:0] S_EMIT      = 5'd16;
    localparam logic [UPC_W-1:0] S_DONE      = 5'd17;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             jump;

    // Control store: operation, jump condition, jump target
    always_comb begin
        ctrl.op     = OP_NONE;
        ctrl.cond   = C_ALWAYS;
        ctrl.target = S_IDLE;
        case (upc_reg)
            S_IDLE:      begin ctrl.op = OP_ACCEPT;    ctrl.cond = C_NO_REQ;
                               ctrl.target = S_IDLE; end
            S_CHK_LOAD:  begin ctrl.cond = C_NOT_LOAD; ctrl.target = S_CHK_START; end
            S_LOAD:      begin ctrl.op = OP_LOAD;      ctrl.target = S_EMIT; end
            S_CHK_START: begin ctrl.cond = C_NOT_START; ctrl.target = S_CHK_TICK; end
            S_START:     begin ctrl.op = OP_START;     ctrl.target = S_EMIT; end
            S_CHK_TICK:  begin ctrl.cond = C_NOT_RUN_TICK; ctrl.target = S_EMIT; end
            S_TICK:      begin ctrl.op = OP_TICK;      ctrl.cond = C_NO_STEP;
                               ctrl.target = S_EMIT; end
            S_SWEEP:     begin ctrl.op = OP_SWEEP;     ctrl.cond = C_SKIP_SWEEP_DIV;
                               ctrl.target = S_CHK_STEPS; end
            S_SDIV_GO:   begin ctrl.op = OP_DIV_START; ctrl.target = S_SDIV_WAIT; end
            S_SDIV_WAIT: begin ctrl.op = OP_DIV_STORE; ctrl.cond = C_DIV_BUSY;
                               ctrl.target = S_SDIV_WAIT; end
            S_CHK_STEPS: begin ctrl.cond = C_STEPS_LEFT; ctrl.target = S_DEC; end
            S_FETCH:     begin ctrl.op = OP_FETCH;     ctrl.cond = C_LEN_ZERO;
                               ctrl.target = S_STOP; end
            S_FDIV_GO:   begin ctrl.op = OP_DIV_START; ctrl.target = S_FDIV_WAIT; end
            S_FDIV_WAIT: begin ctrl.op = OP_DIV_STORE; ctrl.cond = C_DIV_BUSY;
                               ctrl.target = S_FDIV_WAIT; end
            S_DEC:       begin ctrl.op = OP_DEC;       ctrl.target = S_EMIT; end
            S_STOP:      begin ctrl.op = OP_STOP;      ctrl.target = S_EMIT; end
            S_EMIT:      begin ctrl.op = OP_EMIT;      ctrl.cond = C_OUT_BUSY;
                               ctrl.target = S_EMIT; end
            S_DONE:      begin ctrl.target = S_IDLE; end
            default:     begin ctrl.target = S_IDLE; end
        endcase
    end

    // Condition select
    always_comb begin
        unique case (ctrl.cond)
            C_ALWAYS:         jump = 1'b1;
            C_NO_REQ:         jump = !flags.req;
            C_NOT_LOAD:       jump = !flags.is_load;
            C_NOT_START:      jump = !flags.is_start;
            C_NOT_RUN_TICK:   jump = !flags.run_tick;
            C_NO_STEP:        jump = !flags.step_due;
            C_SKIP_SWEEP_DIV: jump = flags.skip_sweep_div;
            C_DIV_BUSY:       jump = flags.div_busy;
            C_STEPS_LEFT:     jump = flags.steps_nonzero;
            C_LEN_ZERO:       jump = flags.len_zero;
            C_OUT_BUSY:       jump = flags.out_busy;
            default:          jump = 1'b1;
        endcase
        upc_next = jump ? ctrl.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= S_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> src/tone_sequencer_with_sweep.sv
// Requests are handled one at a time: a load, start, no-op or tick passes through the microcode
// states in turn, and the next request is taken after the result is posted. The divider runs at
// most once per step (a sweep on a step that fetches a new note is not divided). A result held
// by m_ready stalls the next one.
// Sync reset (aresetn low) stops playback, zeroes state and divider, reloads config defaults.
`include "tone_sequencer_with_sweep_defines.svh"

module tone_sequencer_with_sweep
    import tss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [NUMERATOR_W-1:0] cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tss_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tss_out_t               m_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    tss_ctrl_t  ctrl;
    tss_flags_t flags;

    logic [NUMERATOR_W-1:0] numerator_reg;
    logic [TPS_W-1:0]       tps_reg;

    tss_in_t                item_reg;
    logic                   playing_reg;
    logic [AW-1:0]          rdpos_reg;
    logic [FREQ_W-1:0]      freq_reg;
    logic [15:0]            steps_reg;
    logic [15:0]            sweep_reg;
    logic [TPS_W-1:0]       tick_reg;
    logic [NUMERATOR_W-1:0] divider_reg;
    logic                   written_reg;
    logic                   m_valid_reg;
    tss_out_t               m_data_reg;

    tss_entry_t             rd_entry;
    tss_entry_t             wr_entry;
    logic                   div_busy;
    logic [NUMERATOR_W-1:0] quotient;

    logic [15:0]            start_rem;
    logic [AW-1:0]          start_pos;
    logic [AW-1:0]          rdpos_next;
    logic [TPS_W:0]         tick_next;
    logic                   load_in_range;
    logic                   accept;
    logic                   out_busy;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            numerator_reg <= NUMERATOR_RST;
            tps_reg       <= TPS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NUMERATOR: numerator_reg <= cfg_wdata;
                CFG_TPS:       tps_reg       <= cfg_wdata[TPS_W-1:0];
                default:       ;
            endcase
        end
    end

    // Start position modulo table depth: at most 16 table lengths fit in 8 bits
    always_comb begin
        start_rem = 16'(item_reg.start_index);
        for (int k = 3; k >= 0; k--) begin
            if (start_rem >= 16'(TABLE_DEPTH << k)) begin
                start_rem = start_rem - 16'(TABLE_DEPTH << k);
            end
        end
        start_pos = AW'(start_rem);
    end

    // Read position wrap and tick counter increment
    always_comb begin
        rdpos_next    = ({1'b0, rdpos_reg} + 1'b1 == (AW+1)'(TABLE_DEPTH)) ? '0
                        : rdpos_reg + 1'b1;
        tick_next     = {1'b0, tick_reg} + 1'b1;
        load_in_range = int'(item_reg.entry_index) < TABLE_DEPTH;
        wr_entry      = '{length: item_reg.entry_length, note: item_reg.entry_note,
                          sweep: item_reg.entry_sweep};
    end

    assign out_busy = m_valid_reg && !m_ready;
    assign s_ready  = aresetn && (ctrl.op == OP_ACCEPT);
    assign accept   = s_valid && s_ready;

    // Status for the sequencer
    always_comb begin
        flags.req            = s_valid;
        flags.is_load        = item_reg.action == ACT_LOAD;
        flags.is_start       = item_reg.action == ACT_START;
        flags.run_tick       = (item_reg.action == ACT_TICK) && playing_reg;
        flags.step_due       = tick_next >= {1'b0, tps_reg};
        flags.skip_sweep_div = (sweep_reg == '0) ||
                               ((steps_reg == '0) && (rd_entry.length != '0));
        flags.div_busy       = div_busy;
        flags.steps_nonzero  = steps_reg != '0;
        flags.len_zero       = rd_entry.length == '0;
        flags.out_busy       = out_busy;
    end

    tss_ucode u_ucode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    tss_note_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_note_ram (
        .aclk    (aclk),
        .wr_en   ((ctrl.op == OP_LOAD) && load_in_range),
        .wr_addr (AW'(item_reg.entry_index)),
        .wr_data (wr_entry),
        .rd_en   (ctrl.op == OP_TICK),
        .rd_addr (rdpos_reg),
        .rd_data (rd_entry)
    );

    tss_divider u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (ctrl.op == OP_DIV_START),
        .numerator   (numerator_reg),
        .denominator (freq_reg),
        .busy        (div_busy),
        .quotient    (quotient)
    );

    // Request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
    end

    // Sequencer state, driven by the current control word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg <= 1'b0;
            rdpos_reg   <= '0;
            freq_reg    <= '0;
            steps_reg   <= '0;
            sweep_reg   <= '0;
            tick_reg    <= '0;
            divider_reg <= '0;
            written_reg <= 1'b0;
        end else begin
            case (ctrl.op)
                OP_ACCEPT: begin
                    if (accept) begin
                        written_reg <= 1'b0;
                    end
                end
                OP_START: begin
                    rdpos_reg   <= start_pos;
                    steps_reg   <= '0;
                    tick_reg    <= tps_reg;
                    playing_reg <= 1'b1;
                end
                OP_TICK: begin
                    tick_reg <= flags.step_due ? '0 : tick_next[TPS_W-1:0];
                end
                OP_SWEEP: begin
                    if (sweep_reg != '0) begin
                        freq_reg    <= freq_reg + sweep_reg;
                        written_reg <= 1'b1;
                    end
                end
                OP_DIV_STORE: begin
                    if (!div_busy) begin
                        divider_reg <= quotient;
                    end
                end
                OP_FETCH: begin
                    if (rd_entry.length != '0) begin
                        freq_reg    <= rd_entry.note;
                        steps_reg   <= rd_entry.length;
                        sweep_reg   <= rd_entry.sweep;
                        rdpos_reg   <= rdpos_next;
                        written_reg <= 1'b1;
                    end
                end
                OP_DEC:  steps_reg   <= steps_reg - 1'b1;
                OP_STOP: playing_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((ctrl.op == OP_EMIT) && !out_busy) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((ctrl.op == OP_EMIT) && !out_busy) begin
            m_data_reg <= '{tone_on: playing_reg, divider: divider_reg,
                            divider_written: written_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The divider is never restarted while an iteration is in flight
    `TSS_ASSERT_NOW(a_div_start_idle, ctrl.op == OP_DIV_START, !div_busy)
    // The read position always addresses a table entry
    `TSS_ASSERT_NOW(a_rdpos_range, 1'b1, int'(rdpos_reg) < TABLE_DEPTH)
    // A fresh request starts with the divider-written flag clear
    `TSS_ASSERT_NEXT(a_written_clear, accept, !written_reg)
    // An end entry turns the tone off
    `TSS_ASSERT_NEXT(a_stop_off, ctrl.op == OP_STOP, !playing_reg)
    // No request is taken while the sequencer is still working or emitting
    `TSS_ASSERT_NOW(a_accept_idle, accept, ctrl.op != OP_EMIT)

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tss_pkg::*;

    // Action code with no function, not named in the package
    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int TBL_DEPTH       = 256;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam tss_out_t RES_IDLE  = '0;
    localparam tss_out_t RES_PLAY0 = '{tone_on: 1'b1, divider: 24'd0, divider_written: 1'b0};
    localparam tss_out_t RES_FREQ0 = '{tone_on: 1'b1, divider: 24'hFFFFFF,
                                       divider_written: 1'b1};

    typedef struct {
        tss_in_t  req;
        logic     chk;
        tss_out_t want;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [NUMERATOR_W-1:0] cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    tss_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    tss_out_t               m_data;

    tone_sequencer_with_sweep DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Sequencer shadow state
    logic [15:0]            tbl_len   [TBL_DEPTH];
    logic [15:0]            tbl_note  [TBL_DEPTH];
    logic [15:0]            tbl_sweep [TBL_DEPTH];
    bit                     tbl_loaded[TBL_DEPTH];
    logic                   tone_playing;
    logic [7:0]             play_pos;
    logic [15:0]            run_freq;
    logic [15:0]            steps_left;
    logic [15:0]            run_sweep;
    logic [9:0]             tick_cnt;
    logic [23:0]            div_val;
    logic [NUMERATOR_W-1:0] cfg_numer;
    logic [TPS_W-1:0]       cfg_step_ticks;

    tss_out_t tone_exp_q[$];
    int       fails;
    int       send_idle;
    int       recv_idle;
    bit       hold_go = 1'b0;
    int       hold_left = 0;
    int       cycle_cnt = 0;
    dir_row_t dir_tab[23];

    function automatic logic [23:0] divide_by_freq(logic [15:0] f);
        if (f == 16'd0)
            return 24'hFFFFFF;
        return 24'(cfg_numer / f);
    endfunction

    // Advance the shadow state by one request, return the expected result
    function automatic tss_out_t predict_tone(tss_in_t rq);
        logic       wr;
        logic [10:0] nxt;
        wr = 1'b0;
        case (rq.action)
            ACT_LOAD: begin
                tbl_len[rq.entry_index]    = rq.entry_length;
                tbl_note[rq.entry_index]   = rq.entry_note;
                tbl_sweep[rq.entry_index]  = rq.entry_sweep;
                tbl_loaded[rq.entry_index] = 1'b1;
            end
            ACT_START: begin
                play_pos     = rq.start_index;
                steps_left   = 16'd0;
                tick_cnt     = cfg_step_ticks;
                tone_playing = 1'b1;
            end
            ACT_TICK: begin
                if (tone_playing) begin
                    nxt = {1'b0, tick_cnt} + 11'd1;
                    if (nxt >= {1'b0, cfg_step_ticks}) begin
                        tick_cnt = '0;
                        // sweep first, then fetch when the note has run out
                        if (run_sweep != 16'd0) begin
                            run_freq = run_freq + run_sweep;
                            div_val  = divide_by_freq(run_freq);
                            wr       = 1'b1;
                        end
                        if (steps_left == 16'd0) begin
                            if (tbl_len[play_pos] == 16'd0) begin
                                tone_playing = 1'b0;
                            end else begin
                                run_freq   = tbl_note[play_pos];
                                div_val    = divide_by_freq(run_freq);
                                wr         = 1'b1;
                                steps_left = tbl_len[play_pos];
                                run_sweep  = tbl_sweep[play_pos];
                                play_pos   = play_pos + 8'd1;
                            end
                        end
                        if (tone_playing)
                            steps_left = steps_left - 16'd1;
                    end else begin
                        tick_cnt = nxt[9:0];
                    end
                end
            end
            default: ;
        endcase
        return '{tone_on: tone_playing, divider: div_val, divider_written: wr};
    endfunction

    function automatic tss_in_t mk_req(logic [1:0] a, logic [7:0] ix, logic [15:0] len,
                                       logic [15:0] note, logic [15:0] swp, logic [7:0] st);
        tss_in_t rq;
        rq.action       = a;
        rq.entry_index  = ix;
        rq.entry_length = len;
        rq.entry_note   = note;
        rq.entry_sweep  = swp;
        rq.start_index  = st;
        return rq;
    endfunction

    // Random request; never lets playback fetch an entry that was never loaded
    function automatic tss_in_t next_random_req();
        tss_in_t rq;
        int      r;
        int      pick;
        logic [7:0] fix_ix;
        bit      fix;
        rq.entry_index  = 8'($urandom);
        rq.start_index  = 8'($urandom);
        rq.entry_note   = 16'($urandom);
        rq.entry_length = 16'($urandom);
        rq.entry_sweep  = 16'($urandom);
        fix    = 1'b0;
        fix_ix = '0;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            rq.action = ACT_NOP;
        end else if (r < 22) begin
            rq.action = ACT_LOAD;
        end else if (r < 30) begin
            rq.action = ACT_START;
            if (!tbl_loaded[rq.start_index]) begin
                fix    = 1'b1;
                fix_ix = rq.start_index;
            end
        end else begin
            rq.action = ACT_TICK;
            if (tone_playing && steps_left == 16'd0 && !tbl_loaded[play_pos] &&
                ({1'b0, tick_cnt} + 11'd1 >= {1'b0, cfg_step_ticks})) begin
                fix    = 1'b1;
                fix_ix = play_pos;
            end
        end
        if (fix) begin
            rq.action      = ACT_LOAD;
            rq.entry_index = fix_ix;
        end
        if (rq.action == ACT_LOAD) begin
            // mostly short notes with audible pitches and gentle sweeps
            pick = $urandom_range(0, 99);
            if (pick < 10)
                rq.entry_length = 16'd0;
            else if (pick < 80)
                rq.entry_length = 16'($urandom_range(1, 4));
            else if (pick < 95)
                rq.entry_length = 16'($urandom_range(5, 40));
            pick = $urandom_range(0, 99);
            if (pick < 10)
                rq.entry_note = 16'd0;
            else if (pick < 80)
                rq.entry_note = 16'($urandom_range(100, 4000));
            pick = $urandom_range(0, 99);
            if (pick < 50)
                rq.entry_sweep = 16'd0;
            else if (pick < 80)
                rq.entry_sweep = 16'($signed($urandom_range(0, 100)) - 50);
        end
        return rq;
    endfunction

    // Offer one request, wait for it to be taken, queue its expected result
    task automatic send_req(input tss_in_t rq, input logic chk, input tss_out_t want);
        int       gap;
        tss_out_t pred;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
        pred = predict_tone(rq);
        tone_exp_q.push_back(chk ? want : pred);
    endtask

    // Let every result come back, then write both registers
    task automatic set_tone_config(input logic [NUMERATOR_W-1:0] numer,
                                   input logic [TPS_W-1:0] ticks);
        s_valid <= 1'b0;
        while (tone_exp_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NUMERATOR;
        cfg_wdata <= numer;
        cfg_numer  = numer;
        @(posedge aclk);
        cfg_index <= CFG_TPS;
        cfg_wdata <= NUMERATOR_W'(ticks);
        cfg_step_ticks = ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [NUMERATOR_W-1:0] numer, input logic [TPS_W-1:0] ticks,
                             input int s_idle, input int r_idle, input int n, input bit hold);
        set_tone_config(numer, ticks);
        send_idle = s_idle;
        recv_idle = r_idle;
        if (hold)
            hold_go = 1'b1;
        repeat (n)
            send_req(next_random_req(), 1'b0, RES_IDLE);
    endtask

    // Result side: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Compare each returned result with the oldest expectation
    always @(posedge aclk) begin
        tss_out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (tone_exp_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: on=%0b div=%06h wr=%0b",
                             m_data.tone_on, m_data.divider, m_data.divider_written);
            end else begin
                exp_res = tone_exp_q.pop_front();
                if (m_data.tone_on !== exp_res.tone_on ||
                    m_data.divider !== exp_res.divider ||
                    m_data.divider_written !== exp_res.divider_written) begin
                    fails++;
                    if (fails <= 10)
                        $display("result mismatch: exp on=%0b div=%06h wr=%0b, got on=%0b div=%06h wr=%0b",
                                 exp_res.tone_on, exp_res.divider, exp_res.divider_written,
                                 m_data.tone_on, m_data.divider, m_data.divider_written);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        fails     = 0;
        send_idle = 21;
        recv_idle = 74;

        // shadow state after reset
        for (int i = 0; i < TBL_DEPTH; i++) begin
            tbl_len[i]    = '0;
            tbl_note[i]   = '0;
            tbl_sweep[i]  = '0;
            tbl_loaded[i] = 1'b0;
        end
        tone_playing   = 1'b0;
        play_pos       = '0;
        run_freq       = '0;
        steps_left     = '0;
        run_sweep      = '0;
        tick_cnt       = '0;
        div_val        = '0;
        cfg_numer      = NUMERATOR_RST;
        cfg_step_ticks = TPS_RST;

        // Directed requests at the reset configuration
        dir_tab = '{
            // idle tick and the unused action code
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b1, RES_IDLE},
            '{mk_req(ACT_NOP, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b1, RES_IDLE},
            // song: 0 -> 1 -> 2 (end); 255 wraps to 0; 3 is a very long note
            '{mk_req(ACT_LOAD, 8'd0, 16'd2, 16'd440, 16'd0, 8'h00), 1'b1, RES_IDLE},
            '{mk_req(ACT_LOAD, 8'd1, 16'd1, 16'd0, 16'd100, 8'h00), 1'b1, RES_IDLE},
            '{mk_req(ACT_LOAD, 8'd2, 16'd0, 16'hFFFF, 16'h7FFF, 8'h00), 1'b1, RES_IDLE},
            '{mk_req(ACT_LOAD, 8'd255, 16'd1, 16'hFFFF, 16'h8000, 8'h00), 1'b1, RES_IDLE},
            '{mk_req(ACT_LOAD, 8'd3, 16'hFFFF, 16'd1, 16'h7FFF, 8'h00), 1'b1, RES_IDLE},
            '{mk_req(ACT_START, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'd0), 1'b1, RES_PLAY0},
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b0, RES_IDLE},
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b0, RES_IDLE},
            // restart while playing
            '{mk_req(ACT_START, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'd0), 1'b0, RES_IDLE},
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b0, RES_IDLE},
            // zero frequency saturates the divider
            '{mk_req(ACT_START, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'd1), 1'b0, RES_IDLE},
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b1, RES_FREQ0},
            // leftover sweep, then the end entry stops playback
            '{mk_req(ACT_START, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'd2), 1'b0, RES_IDLE},
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b0, RES_IDLE},
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b0, RES_IDLE},
            // last table slot, position wraps
            '{mk_req(ACT_START, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'd255), 1'b0, RES_IDLE},
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b0, RES_IDLE},
            // most negative sweep wraps the frequency, then the longest note
            '{mk_req(ACT_START, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'd3), 1'b0, RES_IDLE},
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b0, RES_IDLE},
            '{mk_req(ACT_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0, RES_IDLE},
            '{mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b0, RES_IDLE}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].chk, dir_tab[i].want);

        // Random phases; step period extremes and a lowered period mid-play
        run_phase(24'hFFFFFF, 10'd1, 21, 74, 250, 1'b0);
        run_phase(24'd1, 10'd3, 21, 74, 240, 1'b0);
        run_phase(24'($urandom_range(1, 16777215)), 10'd1023, 74, 21, 200, 1'b0);
        run_phase(24'($urandom_range(1, 16777215)), 10'd2, 74, 21, 250, 1'b0);
        run_phase(24'($urandom_range(1, 16777215)), 10'($urandom_range(1, 6)), 0, 0, 260, 1'b1);
        run_phase(24'd12345, 10'd1, 0, 0, 250, 1'b0);

        // Drain and report
        s_valid <= 1'b0;
        while (tone_exp_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        fails += tone_exp_q.size();
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
